/* design/udiv_pkg.sv */
// Shared types and constants for the double-by-single word unsigned divider.
`timescale 1ns / 1ps
`default_nettype none

package udiv_pkg;

  localparam int unsigned PORT_BITS = 64;

  typedef struct packed {
    logic load;
    logic zero;
    logic step;
  } ctrl_t;

endpackage

`default_nettype wire

/* design/udiv_core.sv */
// Restoring radix-2 divide datapath: partial remainder, dividend/quotient shifter, subtractor.
`timescale 1ns / 1ps
`default_nettype none

module udiv_core #(
  parameter int unsigned WORD_BITS = 64
) (
  input  wire logic                 clk,
  input  wire udiv_pkg::ctrl_t      ctrl,
  input  wire logic [WORD_BITS-1:0] load_high,
  input  wire logic [WORD_BITS-1:0] load_low,
  input  wire logic [WORD_BITS-1:0] load_divisor,
  output logic      [WORD_BITS-1:0] quot_high,
  output logic      [WORD_BITS-1:0] quot_low,
  output logic      [WORD_BITS-1:0] rem
);

  logic [WORD_BITS-1:0] hi;
  logic [WORD_BITS-1:0] lo;
  logic [WORD_BITS-1:0] r;
  logic [WORD_BITS-1:0] d;

  logic [WORD_BITS-1:0] r_shift;
  logic [WORD_BITS-1:0] diff;
  logic                 take;
  logic [WORD_BITS-1:0] hi_next;
  logic [WORD_BITS-1:0] lo_next;
  logic [WORD_BITS-1:0] r_next;

  always_comb begin
    r_shift = {r[WORD_BITS-2:0], hi[WORD_BITS-1]};
    diff    = r_shift - d;
    take    = r[WORD_BITS-1] | (r_shift >= d);
    r_next  = take ? diff : r_shift;
    hi_next = {hi[WORD_BITS-2:0], lo[WORD_BITS-1]};
    lo_next = {lo[WORD_BITS-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      hi <= ctrl.zero ? '0 : load_high;
      lo <= ctrl.zero ? '0 : load_low;
      r  <= '0;
      d  <= load_divisor;
    end else if (ctrl.step) begin
      hi <= hi_next;
      lo <= lo_next;
      r  <= r_next;
    end
  end

  assign quot_high = hi;
  assign quot_low  = lo;
  assign rem       = r;

endmodule

`default_nettype wire

/* design/unsigned_divide_double_by_single.sv */
// Top level of the unsigned double-word by single-word divider.
`timescale 1ns / 1ps
`default_nettype none

// Divides the two-word dividend {dividend_high, dividend_low} by divisor and
// returns the two-word quotient and the remainder. A beat is taken when start
// is high and busy is low. A nonzero divisor runs through the one shared
// subtract-and-shift unit, one quotient bit per cycle, and done pulses for
// one cycle in the cycle after the last bit; busy is already low then, so
// the next start can be taken in that cycle. A zero divisor skips the loop:
// done pulses in the next cycle with divide_by_zero set and all results zero.
// Results are valid in the done cycle and stay until the next start is taken;
// they cannot be held off. Input bits at and above WORD_BITS are ignored;
// output bits there are zero.
module unsigned_divide_double_by_single #(
  parameter int unsigned WORD_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] dividend_high,
  input  wire logic [63:0] dividend_low,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic      [63:0] quotient_high,
  output logic      [63:0] quotient_low,
  output logic      [63:0] remainder,
  output logic             divide_by_zero
);

  localparam int unsigned STEPS = 2 * WORD_BITS;
  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t          state;
  logic [CNT_W-1:0] cnt;
  logic            dz;
  logic            zero_div;
  udiv_pkg::ctrl_t ctrl;

  logic [WORD_BITS-1:0] core_high;
  logic [WORD_BITS-1:0] core_low;
  logic [WORD_BITS-1:0] core_rem;

  assign zero_div  = (divisor[WORD_BITS-1:0] == '0);
  assign busy      = (state == S_RUN);
  assign ctrl.load = start && (state == S_IDLE);
  assign ctrl.zero = zero_div;
  assign ctrl.step = (state == S_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      dz    <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            dz  <= zero_div;
            cnt <= '0;
            if (zero_div) begin
              done <= 1'b1;
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (cnt == CNT_LAST) begin
            state <= S_IDLE;
            done  <= 1'b1;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  udiv_core #(
    .WORD_BITS(WORD_BITS)
  ) u_core (
    .clk         (clk),
    .ctrl        (ctrl),
    .load_high   (dividend_high[WORD_BITS-1:0]),
    .load_low    (dividend_low[WORD_BITS-1:0]),
    .load_divisor(divisor[WORD_BITS-1:0]),
    .quot_high   (core_high),
    .quot_low    (core_low),
    .rem         (core_rem)
  );

  assign quotient_high  = udiv_pkg::PORT_BITS'(core_high);
  assign quotient_low   = udiv_pkg::PORT_BITS'(core_low);
  assign remainder      = udiv_pkg::PORT_BITS'(core_rem);
  assign divide_by_zero = dz;

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted beat neither started the loop nor finished");

  a_finish_strobe: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("loop ended without a done strobe");

  a_zero_results: assert property (@(posedge clk) disable iff (rst)
    (done && divide_by_zero) |->
      (quotient_high == '0 && quotient_low == '0 && remainder == '0))
    else $error("zero divisor gave nonzero results");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE && (dz || cnt == '0)))
    else $error("done raised outside idle or with counter not wrapped");

endmodule

`default_nettype wire

/* verif/unsigned_divide_double_by_single_checker.sv */
// Checker that predicts and compares every result beat of the double-by-single word divider.
`timescale 1ns / 1ps

module unsigned_divide_double_by_single_checker #(
  parameter int unsigned WORD_BITS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic                            busy,
  input  wire logic [udiv_pkg::PORT_BITS-1:0] dividend_high,
  input  wire logic [udiv_pkg::PORT_BITS-1:0] dividend_low,
  input  wire logic [udiv_pkg::PORT_BITS-1:0] divisor,
  input  wire logic                            done,
  input  wire logic [udiv_pkg::PORT_BITS-1:0] quotient_high,
  input  wire logic [udiv_pkg::PORT_BITS-1:0] quotient_low,
  input  wire logic [udiv_pkg::PORT_BITS-1:0] remainder,
  input  wire logic                            divide_by_zero,
  output int                                   fails,
  output int                                   pending
);
  localparam int unsigned PORT_BITS = udiv_pkg::PORT_BITS;

  localparam logic [PORT_BITS-1:0] WORD_MASK = {PORT_BITS{1'b1}} >> (PORT_BITS - WORD_BITS);

  typedef struct packed {
    logic [PORT_BITS-1:0] quo_high;
    logic [PORT_BITS-1:0] quo_low;
    logic [PORT_BITS-1:0] rem;
    logic                 zero_div;
  } quotient_t;

  quotient_t awaited_quotients[$];

  function automatic quotient_t divide_words(input logic [PORT_BITS-1:0] hi,
                                             input logic [PORT_BITS-1:0] lo,
                                             input logic [PORT_BITS-1:0] den);
    logic [2*PORT_BITS-1:0] num;
    logic [2*PORT_BITS-1:0] quo;
    logic [2*PORT_BITS-1:0] rem;
    logic [2*PORT_BITS-1:0] den_wide;
    logic [2*PORT_BITS-1:0] quo_top;
    quotient_t              res;
    res      = '0;
    den_wide = {{PORT_BITS{1'b0}}, den & WORD_MASK};
    num      = ({{PORT_BITS{1'b0}}, hi & WORD_MASK} << WORD_BITS)
             | {{PORT_BITS{1'b0}}, lo & WORD_MASK};
    if (den_wide == '0) begin
      res.zero_div = 1'b1;
    end else begin
      quo          = num / den_wide;
      rem          = num % den_wide;
      quo_top      = quo >> WORD_BITS;
      res.quo_low  = quo[PORT_BITS-1:0] & WORD_MASK;
      res.quo_high = quo_top[PORT_BITS-1:0] & WORD_MASK;
      res.rem      = rem[PORT_BITS-1:0];
    end
    return res;
  endfunction

  function automatic int check_word(input string field, input logic [PORT_BITS-1:0] want,
                                    input logic [PORT_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch_beats
    int        errs;
    quotient_t want;
    errs = 0;
    if (!rst) begin
      if (done) begin
        if (awaited_quotients.size() == 0) begin
          $display("%0t: result beat with nothing outstanding, actual q=%h_%h r=%h z=%b",
                   $time, quotient_high, quotient_low, remainder, divide_by_zero);
          errs = 1;
        end else begin
          want = awaited_quotients.pop_front();
          errs += check_word("quotient_high", want.quo_high, quotient_high);
          errs += check_word("quotient_low", want.quo_low, quotient_low);
          errs += check_word("remainder", want.rem, remainder);
          if (divide_by_zero !== want.zero_div) begin
            $display("%0t: divide_by_zero mismatch, expected %b actual %b",
                     $time, want.zero_div, divide_by_zero);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        awaited_quotients.push_back(divide_words(dividend_high, dividend_low, divisor));
      end
    end
    fails   <= fails + errs;
    pending <= awaited_quotients.size();
  end

endmodule

/* verif/unsigned_divide_double_by_single_tb.sv */
// Testbench top: drives divide beats in bursts and reports the verdict from the checker.
`timescale 1ns / 1ps

module unsigned_divide_double_by_single_tb;
  localparam int unsigned PORT_BITS = udiv_pkg::PORT_BITS;

  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned NUM_RANDOM = 500;
  localparam logic [PORT_BITS-1:0] ALL_ONES = {PORT_BITS{1'b1}};
  localparam logic [PORT_BITS-1:0] TOP_BIT  = {1'b1, {(PORT_BITS-1){1'b0}}};
  localparam logic [PORT_BITS-1:0] ONE      = PORT_BITS'(1);

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [PORT_BITS-1:0] dividend_high = '0;
  logic [PORT_BITS-1:0] dividend_low = '0;
  logic [PORT_BITS-1:0] divisor = '0;
  logic                 busy;
  logic                 done;
  logic [PORT_BITS-1:0] quotient_high;
  logic [PORT_BITS-1:0] quotient_low;
  logic [PORT_BITS-1:0] remainder;
  logic                 divide_by_zero;
  int                   fails;
  int                   pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  unsigned_divide_double_by_single #(.WORD_BITS(WORD_BITS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .dividend_high(dividend_high), .dividend_low(dividend_low), .divisor(divisor),
    .done(done), .quotient_high(quotient_high), .quotient_low(quotient_low),
    .remainder(remainder), .divide_by_zero(divide_by_zero)
  );

  unsigned_divide_double_by_single_checker #(.WORD_BITS(WORD_BITS)) checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .dividend_high(dividend_high), .dividend_low(dividend_low), .divisor(divisor),
    .done(done), .quotient_high(quotient_high), .quotient_low(quotient_low),
    .remainder(remainder), .divide_by_zero(divide_by_zero),
    .fails(fails), .pending(pending)
  );

  function automatic logic [PORT_BITS-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_division(input logic [PORT_BITS-1:0] hi, input logic [PORT_BITS-1:0] lo,
                               input logic [PORT_BITS-1:0] den);
    @(negedge clk);
    start         <= 1'b1;
    dividend_high <= hi;
    dividend_low  <= lo;
    divisor       <= den;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic send_random_division();
    logic [PORT_BITS-1:0] hi;
    logic [PORT_BITS-1:0] lo;
    logic [PORT_BITS-1:0] den;
    hi  = rand_word();
    lo  = rand_word();
    den = rand_word();
    case ($urandom_range(0, 9))
      0: den = '0;
      1: den = PORT_BITS'($urandom_range(1, 255));
      2: den = ONE << $urandom_range(0, PORT_BITS - 1);
      3: den = ALL_ONES - PORT_BITS'($urandom_range(0, 15));
      4: begin
        if (den == '0) den = ONE;
        hi = den - ONE;
      end
      5: begin
        if (den == '0) den = ONE;
        hi = hi % den;
      end
      6: hi = '0;
      default: ;
    endcase
    send_division(hi, lo, den);
  endtask

  initial begin
    int burst;
    int sent;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_division('0, '0, ONE);
    send_division(ALL_ONES, ALL_ONES, ONE);
    send_division(ALL_ONES, ALL_ONES, ALL_ONES);
    send_division(ALL_ONES, ALL_ONES, '0);
    send_division('0, '0, '0);
    send_division('0, PORT_BITS'(7), PORT_BITS'(3));
    send_division('0, PORT_BITS'(5), PORT_BITS'(9));
    send_division('0, ALL_ONES, ALL_ONES);
    send_division(ALL_ONES - ONE, ALL_ONES, ALL_ONES);
    send_division(TOP_BIT - ONE, ALL_ONES, TOP_BIT);
    send_division(TOP_BIT, '0, TOP_BIT);
    send_division(ALL_ONES, '0, PORT_BITS'(2));
    send_division(ONE, '0, ALL_ONES);
    hold_off(5);
    send_division(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 64'h0000_0001_0000_0001);
    send_division('0, TOP_BIT, TOP_BIT + ONE);
    send_division(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 64'h3);
    hold_off(40);
    send_division(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, '0);

    sent = 0;
    while (sent < NUM_RANDOM) begin
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      repeat (burst) begin
        send_random_division();
        sent++;
      end
      case ($urandom_range(0, 3))
        0: hold_off(0);
        1: hold_off($urandom_range(1, 4));
        2: hold_off($urandom_range(5, 2 * WORD_BITS + 10));
        default: hold_off($urandom_range(1, 20));
      endcase
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2 * WORD_BITS + 10) @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
